@@ rtl/bmap_pkg.sv @@
package bmap_pkg;

    // Number of coordinate lanes carried by one item.
    localparam int LANES = 4;

    // Coordinate and index width.
    localparam int CW = 16;

    // Length register width.
    localparam int LW = 15;

    // Border mode codes.
    localparam logic [2:0] MODE_CONSTANT   = 3'd0;
    localparam logic [2:0] MODE_REPLICATE  = 3'd1;
    localparam logic [2:0] MODE_REFLECT    = 3'd2;
    localparam logic [2:0] MODE_WRAP       = 3'd3;
    localparam logic [2:0] MODE_REFLECT101 = 3'd4;

    // Configuration register indexes.
    localparam logic [0:0] REG_BORDER_MODE = 1'd0;
    localparam logic [0:0] REG_ROW_LENGTH  = 1'd1;

    // Lane sequencer states.
    typedef enum logic [2:0] {
        LS_IDLE,
        LS_DIV,
        LS_FIX,
        LS_FOLD,
        LS_DONE
    } lane_state_t;

    // Status that a lane reports to the merging stage.
    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] index;
    } lane_stat_t;

endpackage

@@ rtl/bmap_lane.sv @@
module bmap_lane
    import bmap_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic                 ack,
    input  logic signed [CW-1:0] coord,
    input  logic [2:0]           border_mode,
    input  logic [LW-1:0]        row_length,
    output lane_stat_t           stat
);

    lane_state_t     state_reg, state_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic            neg_reg, neg_next;
    logic [CW-1:0]   dvd_reg, dvd_next;
    logic [16:0]     rem_reg, rem_next;
    logic [16:0]     m_reg, m_next;
    logic [CW-1:0]   result_reg, result_next;

    logic [CW-1:0]   mag;
    logic            in_range;
    logic            bad;
    logic [16:0]     period;
    logic [17:0]     trial;
    logic [16:0]     len_ext;

    // The period of the floored modulo depends only on the configuration.
    always_comb begin
        len_ext = {2'b00, row_length};
        case (border_mode)
            MODE_REFLECT:    period = {1'b0, row_length, 1'b0};
            MODE_REFLECT101: period = {1'b0, row_length, 1'b0} - 17'd2;
            default:         period = len_ext;
        endcase
    end

    assign mag      = coord[CW-1] ? (~coord + 16'd1) : coord;
    assign in_range = !coord[CW-1] && (coord[LW-1:0] < row_length);
    assign bad      = border_mode > MODE_REFLECT101;
    assign trial    = {rem_reg, dvd_reg[CW-1]};

    // Sequencer: classify, restoring remainder one bit a cycle, sign fix, fold.
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        m_next      = m_reg;
        result_next = result_reg;
        case (state_reg)
            LS_IDLE: begin
                if (start) begin
                    neg_next = coord[CW-1];
                    dvd_next = mag;
                    rem_next = '0;
                    cnt_next = '0;
                    state_next = LS_DONE;
                    if (bad || row_length == '0) begin
                        result_next = '1;
                    end else if (in_range) begin
                        result_next = coord;
                    end else if (border_mode == MODE_CONSTANT) begin
                        result_next = '1;
                    end else if (border_mode == MODE_REPLICATE) begin
                        result_next = coord[CW-1] ? '0 : {1'b0, row_length - 15'd1};
                    end else if ((border_mode == MODE_REFLECT ||
                                  border_mode == MODE_REFLECT101) &&
                                 row_length == 15'd1) begin
                        result_next = '0;
                    end else begin
                        state_next = LS_DIV;
                    end
                end
            end
            LS_DIV: begin
                if (trial >= {1'b0, period}) begin
                    rem_next = 17'(trial - {1'b0, period});
                end else begin
                    rem_next = trial[16:0];
                end
                dvd_next = {dvd_reg[CW-2:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = LS_FIX;
                end
            end
            LS_FIX: begin
                // A negative coordinate with a nonzero remainder wraps upward.
                if (neg_reg && rem_reg != '0) begin
                    m_next = period - rem_reg;
                end else begin
                    m_next = rem_reg;
                end
                state_next = LS_FOLD;
            end
            LS_FOLD: begin
                if (m_reg < len_ext || border_mode == MODE_WRAP) begin
                    result_next = m_reg[CW-1:0];
                end else if (border_mode == MODE_REFLECT) begin
                    result_next = 16'(period - 17'd1 - m_reg);
                end else begin
                    result_next = 16'(period - m_reg);
                end
                state_next = LS_DONE;
            end
            LS_DONE: begin
                if (ack) begin
                    state_next = LS_IDLE;
                end
            end
            default: state_next = LS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        m_reg      <= m_next;
        result_reg <= result_next;
    end

    assign stat.done  = (state_reg == LS_DONE);
    assign stat.index = result_reg;

endmodule

@@ rtl/border_index_mapper.sv @@
// Channel   | Valid / ready      | Payload
// ----------+--------------------+---------------------------------------
// input     | s_valid / s_ready  | s_coord_0 .. s_coord_3
// result    | m_valid / m_ready  | m_index_0 .. m_index_3, m_bad_mode
// config    | cfg_we             | cfg_index, cfg_wdata
//
// One item is in flight at a time. An item that needs a modulo runs through
// the bit-serial remainder loop in each lane (16 steps plus sign fix and
// fold) before its result is ready; other items are mapped directly.
// Reset is synchronous and active low; it sets replicate mode, length 1.
// A result waiting in the output register does not block the next transfer.
module border_index_mapper
    import bmap_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [CW-1:0] s_coord_0,
    input  logic signed [CW-1:0] s_coord_1,
    input  logic signed [CW-1:0] s_coord_2,
    input  logic signed [CW-1:0] s_coord_3,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [CW-1:0] m_index_0,
    output logic signed [CW-1:0] m_index_1,
    output logic signed [CW-1:0] m_index_2,
    output logic signed [CW-1:0] m_index_3,
    output logic                 m_bad_mode,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [LW-1:0]        cfg_wdata
);

    logic [2:0]           mode_reg;
    logic [LW-1:0]        len_reg;
    logic                 busy_reg;
    logic                 m_valid_reg;
    logic signed [CW-1:0] idx_reg [LANES];
    logic                 bad_reg;

    logic signed [CW-1:0] coords [LANES];
    lane_stat_t           stats  [LANES];
    logic [LANES-1:0]     done_vec;
    logic                 start;
    logic                 load;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_REPLICATE;
            len_reg  <= 15'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BORDER_MODE: mode_reg <= cfg_wdata[2:0];
                REG_ROW_LENGTH:  len_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign coords[0] = s_coord_0;
    assign coords[1] = s_coord_1;
    assign coords[2] = s_coord_2;
    assign coords[3] = s_coord_3;

    assign s_ready = !busy_reg;
    assign start   = s_valid && s_ready;

    // Lanes work side by side on the coordinates of one item.
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        bmap_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .start       (start),
            .ack         (load),
            .coord       (coords[i]),
            .border_mode (mode_reg),
            .row_length  (len_reg),
            .stat        (stats[i])
        );
        assign done_vec[i] = stats[i].done;
    end

    // Merge: once all lanes are done and the output is empty or read, load it.
    assign load = busy_reg && (&done_vec) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
            end else if (load) begin
                busy_reg <= 1'b0;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (load) begin
            for (int k = 0; k < LANES; k++) begin
                idx_reg[k] <= stats[k].index;
            end
            bad_reg <= mode_reg > MODE_REFLECT101;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_index_0  = idx_reg[0];
    assign m_index_1  = idx_reg[1];
    assign m_index_2  = idx_reg[2];
    assign m_index_3  = idx_reg[3];
    assign m_bad_mode = bad_reg;

    // The merge stage only fires for an item in flight.
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> busy_reg)
        else $error("merge without an item in flight");

    // A transfer closes the input until the item has been merged.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_ready)
        else $error("second transfer while busy");

    // Lanes sit idle whenever no item is in flight.
    a_lanes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> done_vec == '0)
        else $error("lane done with no item in flight");

    // An unsupported mode forces the constant-border index.
    a_bad_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_mode) |-> (m_index_0 == -16'sd1 && m_index_3 == -16'sd1))
        else $error("bad mode with a mapped index");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import bmap_pkg::*;

    // Four lane coordinates of one input transfer.
    typedef struct {
        logic signed [CW-1:0] coord [LANES];
    } coord_set_t;

    // Expected contents of one result transfer.
    typedef struct {
        logic signed [CW-1:0] index [LANES];
        logic                 bad;
    } index_set_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [CW-1:0] s_coord_0, s_coord_1, s_coord_2, s_coord_3;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [CW-1:0] m_index_0, m_index_1, m_index_2, m_index_3;
    logic                 m_bad_mode;
    logic                 cfg_we;
    logic [0:0]           cfg_index;
    logic [LW-1:0]        cfg_wdata;

    coord_set_t pending_coords [$];
    index_set_t expected_indexes [$];

    // The model's own copy of the two registers.
    logic [2:0]    mdl_mode;
    logic [LW-1:0] mdl_len;

    int  mismatch_count;
    int  cycle_count;
    int  hold_off_cycles;
    bit  in_taken;

    border_index_mapper u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_coord_0  (s_coord_0),
        .s_coord_1  (s_coord_1),
        .s_coord_2  (s_coord_2),
        .s_coord_3  (s_coord_3),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_index_0  (m_index_0),
        .m_index_1  (m_index_1),
        .m_index_2  (m_index_2),
        .m_index_3  (m_index_3),
        .m_bad_mode (m_bad_mode),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Floored remainder of a coordinate over a positive period.
    function automatic int floored_rem(int value, int period);
        int r;
        r = value % period;
        if (r < 0) begin
            r += period;
        end
        return r;
    endfunction

    // Maps one coordinate according to the border mode and row length.
    function automatic logic signed [CW-1:0] border_index(logic signed [CW-1:0] coord,
                                                          logic [2:0] mode,
                                                          logic [LW-1:0] len_bits);
        int p;
        int len;
        int period;
        int m;
        int r;
        p = coord;
        len = len_bits;
        if (mode > MODE_REFLECT101 || len == 0) begin
            r = -1;
        end else if (p >= 0 && p < len) begin
            r = p;
        end else begin
            case (mode)
                MODE_CONSTANT: begin
                    r = -1;
                end
                MODE_REPLICATE: begin
                    r = (p < 0) ? 0 : len - 1;
                end
                MODE_REFLECT: begin
                    if (len == 1) begin
                        r = 0;
                    end else begin
                        period = 2 * len;
                        m = floored_rem(p, period);
                        r = (m < len) ? m : period - 1 - m;
                    end
                end
                MODE_REFLECT101: begin
                    if (len == 1) begin
                        r = 0;
                    end else begin
                        period = 2 * len - 2;
                        m = floored_rem(p, period);
                        r = (m < len) ? m : period - m;
                    end
                end
                default: begin
                    r = floored_rem(p, len);
                end
            endcase
        end
        return CW'(r);
    endfunction

    // Input transfers are taken at the rising edge and mapped right away.
    always @(posedge aclk) begin
        index_set_t exp_set;
        coord_set_t cur;
        if (aresetn && s_valid && s_ready) begin
            cur = pending_coords.pop_front();
            for (int i = 0; i < LANES; i++) begin
                exp_set.index[i] = border_index(cur.coord[i], mdl_mode, mdl_len);
            end
            exp_set.bad = (mdl_mode > MODE_REFLECT101);
            expected_indexes.push_back(exp_set);
            in_taken = 1'b1;
        end
    end

    // Input side: bursts with random gaps.
    int burst_left;
    int gap_left;
    always @(negedge aclk) begin
        coord_set_t cur;
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
            in_taken = 1'b0;
        end else begin
            if (s_valid && !in_taken) begin
                // Hold the offered coordinates until the transfer happens.
            end else if (pending_coords.size() > 0 && gap_left == 0) begin
                cur = pending_coords[0];
                s_valid   <= 1'b1;
                s_coord_0 <= cur.coord[0];
                s_coord_1 <= cur.coord[1];
                s_coord_2 <= cur.coord[2];
                s_coord_3 <= cur.coord[3];
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                end
                burst_left--;
                if (burst_left == 0 && $urandom_range(0, 1)) begin
                    gap_left = $urandom_range(1, 25);
                end
            end else begin
                s_valid <= 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end
            end
            in_taken = 1'b0;
        end
    end

    // Result side stall pattern, with one long hold-off in the first random phase.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles--;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0) || cycle_count[7];
        end
    end

    // Result checking against the oldest expected index set.
    always @(posedge aclk) begin
        index_set_t exp_set;
        logic signed [CW-1:0] got [LANES];
        logic bad_field;
        if (aresetn && m_valid && m_ready) begin
            got[0] = m_index_0;
            got[1] = m_index_1;
            got[2] = m_index_2;
            got[3] = m_index_3;
            if (expected_indexes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result transfer at cycle %0d", cycle_count);
                end
            end else begin
                exp_set = expected_indexes.pop_front();
                bad_field = (m_bad_mode !== exp_set.bad);
                for (int i = 0; i < LANES; i++) begin
                    if (got[i] !== exp_set.index[i]) begin
                        bad_field = 1'b1;
                    end
                end
                if (bad_field) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"mismatch: exp %0d %0d %0d %0d bad=%0b, ",
                                  "got %0d %0d %0d %0d bad=%0b"},
                                 exp_set.index[0], exp_set.index[1], exp_set.index[2],
                                 exp_set.index[3], exp_set.bad,
                                 got[0], got[1], got[2], got[3], m_bad_mode);
                    end
                end
            end
        end
    end

    // Cycle limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 900000) begin
            $display("** border_index_mapper: FAILED **");
            $finish;
        end
    end

    // Picks a coordinate biased toward the edges of the row.
    function automatic logic signed [CW-1:0] pick_coord(int len);
        int sel;
        int r;
        sel = $urandom_range(0, 9);
        case (sel)
            0: r = int'($urandom);
            1: r = -32768 + int'($urandom_range(0, 3));
            2: r = 32767 - int'($urandom_range(0, 3));
            3: r = len - 2 + int'($urandom_range(0, 4));
            4: r = -int'($urandom_range(0, 3));
            5: r = 2 * len - 3 + int'($urandom_range(0, 5));
            6: r = -2 * len + int'($urandom_range(0, 4)) - 2;
            default: r = int'($urandom_range(0, 3 * len)) - len;
        endcase
        return CW'(r);
    endfunction

    task automatic queue_coords(logic signed [CW-1:0] c0, logic signed [CW-1:0] c1,
                                logic signed [CW-1:0] c2, logic signed [CW-1:0] c3);
        coord_set_t cs;
        cs.coord[0] = c0;
        cs.coord[1] = c1;
        cs.coord[2] = c2;
        cs.coord[3] = c3;
        pending_coords.push_back(cs);
    endtask

    // Waits for the pipeline to drain before a register write.
    task automatic wait_drained();
        while (pending_coords.size() > 0 || s_valid || expected_indexes.size() > 0) begin
            @(negedge aclk);
        end
        repeat (25) @(negedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [LW-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_BORDER_MODE) begin
            mdl_mode = data[2:0];
        end else begin
            mdl_len = data;
        end
    endtask

    initial begin
        int lens [6];
        int len;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_coord_0 = '0;
        s_coord_1 = '0;
        s_coord_2 = '0;
        s_coord_3 = '0;
        m_ready   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        mdl_mode  = MODE_REPLICATE;
        mdl_len   = 15'd1;
        mismatch_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings, then extremes of the coordinate range.
        queue_coords(16'sh8000, 16'sh7fff, 16'sh0000, -16'sh1);
        queue_coords(16'sh0001, 16'sh5555, 16'shaaaa, 16'shffff);
        wait_drained();

        // Directed pass over every mode, including the unsupported codes.
        for (int mode = 0; mode < 8; mode++) begin
            write_reg(REG_BORDER_MODE, LW'(mode));
            foreach (lens[k]) begin
                lens[0] = 1; lens[1] = 0; lens[2] = 5; lens[3] = 32767;
                lens[4] = 2; lens[5] = 16384;
            end
            for (int k = 0; k < 3; k++) begin
                write_reg(REG_ROW_LENGTH, LW'(lens[k]));
                queue_coords(16'sh8000, 16'sh7fff, -16'sh1, CW'(lens[k]));
                queue_coords(16'sh0000, CW'(lens[k] - 1), -16'sh7, CW'(2 * lens[k]));
                wait_drained();
            end
        end

        // Random phases, with one long receiver hold-off in the first.
        for (int phase = 0; phase < 26; phase++) begin
            write_reg(REG_BORDER_MODE, LW'($urandom_range(0, 7) < 6 ?
                                           $urandom_range(0, 4) : $urandom_range(5, 7)));
            case ($urandom_range(0, 4))
                0: len = $urandom_range(1, 4);
                1: len = 32767 - $urandom_range(0, 2);
                2: len = $urandom_range(0, 32767);
                default: len = $urandom_range(1, 40);
            endcase
            write_reg(REG_ROW_LENGTH, LW'(len));
            if (phase == 0) begin
                hold_off_cycles = 300;
            end
            for (int n = 0; n < 48; n++) begin
                queue_coords(pick_coord(len), pick_coord(len), pick_coord(len),
                             pick_coord(len));
            end
            wait_drained();
        end

        repeat (40) @(negedge aclk);
        if (mismatch_count == 0 && expected_indexes.size() == 0) begin
            $display("** border_index_mapper: PASSED **");
        end else begin
            $display("** border_index_mapper: FAILED **");
        end
        $finish;
    end

endmodule
